[design/wrs_pkg.sv]
// Package for the word reversal stream block: word store size, derived widths,
// character codes and the sequencer state type. No dependencies.
package wrs_pkg;

  // Word store depth (1 to 63)
  localparam int unsigned WORD_MAX = 63;
  localparam int unsigned CNT_W    = $clog2(WORD_MAX + 1);
  localparam int unsigned ADDR_W   = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_e;

endpackage

[design/word_reverse_stream.sv]
// Word reversal stream top level: word store memory, flush sequencer and
// output register. Depends on wrs_pkg.

// Reverses each word of a byte stream and keeps spaces in place. A word
// character is accepted every cycle while no flush runs and is only stored;
// it gives no result. A space, a NUL byte with a non-empty store, or a word
// character marked end_of_string starts a flush: the stored word comes out
// last character first at one result per cycle while the output side does
// not stall, paced by the single read port of the word store, followed by
// the space itself where one caused the flush. in_stall_o is held high until
// every stored character, and any such space, has been loaded for output.
// Characters beyond the store depth are dropped and word_overflow_o is set
// on every result of that flush. No clearing pass is needed after reset.
module word_reverse_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       word_overflow_o
);
  import wrs_pkg::*;

  localparam logic [CNT_W-1:0] CntMax = CNT_W'(WORD_MAX);
  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             pend_space_q, pend_space_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q;
  logic             out_run_last_q, out_done_q, out_ovf_q;

  logic [7:0]       word_mem [WORD_MAX];

  logic             in_accept;
  logic             is_space, is_nul, is_word;
  logic             push_en;
  logic             out_free;
  logic             load_mem, load_space;
  logic             load_run_last, load_done;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [CNT_W-1:0] cnt_dec;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign is_space = (char_in_i == CHAR_SPACE);
  assign is_nul   = (char_in_i == CHAR_NUL);
  assign is_word  = !is_space && !is_nul;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_dec  = cnt_q - CntOne;
  assign rd_addr  = cnt_dec[ADDR_W-1:0];
  assign wr_addr  = cnt_q[ADDR_W-1:0];
  assign push_en  = in_accept && is_word && (cnt_q < CntMax);

  // Next state and control registers
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    pend_space_d = pend_space_q;
    last_d       = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          last_d = end_of_string_i;
          if (is_space) begin
            pend_space_d = 1'b1;
            state_d      = ST_FLUSH;
          end else if (is_nul) begin
            pend_space_d = 1'b0;
            if (cnt_q != '0) begin
              state_d = ST_FLUSH;
            end else begin
              ovf_d = 1'b0;
            end
          end else begin
            pend_space_d = 1'b0;
            if (push_en) begin
              cnt_d = cnt_q + CntOne;
            end else begin
              ovf_d = 1'b1;
            end
            if (end_of_string_i) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (cnt_q != '0) begin
            cnt_d = cnt_dec;
            if (cnt_q == CntOne && !pend_space_q) begin
              ovf_d   = 1'b0;
              state_d = ST_IDLE;
            end
          end else begin
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register load controls
  always_comb begin
    load_mem      = 1'b0;
    load_space    = 1'b0;
    load_run_last = 1'b0;
    load_done     = 1'b0;
    case (state_q)
      ST_FLUSH: begin
        if (out_free) begin
          if (cnt_q != '0) begin
            load_mem      = 1'b1;
            load_run_last = (cnt_q == CntOne) && !pend_space_q;
            load_done     = (cnt_q == CntOne) && !pend_space_q;
          end else begin
            load_space    = 1'b1;
            load_run_last = 1'b1;
            load_done     = last_q;
          end
        end
      end
      default: begin
        load_mem   = 1'b0;
        load_space = 1'b0;
      end
    endcase
    out_valid_d = (load_mem || load_space) ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      pend_space_q <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      pend_space_q <= pend_space_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Word store write port
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      word_mem[wr_addr] <= char_in_i;
    end
  end

  // Registered read straight into the output register
  always_ff @(posedge clk_i) begin
    if (load_mem) begin
      out_char_q <= word_mem[rd_addr];
    end else if (load_space) begin
      out_char_q <= CHAR_SPACE;
    end
    if (load_mem || load_space) begin
      out_run_last_q <= load_run_last;
      out_done_q     <= load_done;
      out_ovf_q      <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign char_out_o      = out_char_q;
  assign run_last_o      = out_run_last_q;
  assign string_done_o   = out_done_q;
  assign word_overflow_o = out_ovf_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("word count beyond store depth");

  // While collecting, the overflow flag only rises on a full store
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && state_q == ST_IDLE) |-> (cnt_q == CntMax))
    else $error("overflow flag set with store not full");

  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && cnt_q == '0) |-> pend_space_q)
    else $error("flush with empty store and no pending space");

  a_space_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && cnt_q == '0 && out_free) |=>
      (state_q == ST_IDLE && out_valid_q && out_char_q == CHAR_SPACE && !ovf_q))
    else $error("pending space not delivered at end of flush");

endmodule
